// ----- rtl/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and constants of the canonical line editor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

	localparam int LINE_DEPTH_DEF = 32;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7F;

	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_LINE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ECHO_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CRLF_EXPAND = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CR_TO_LF    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_SIZE   = 2'd3;

	localparam logic [5:0] LINE_SIZE_RST = 6'd32;
	localparam logic [5:0] LINE_SIZE_MIN = 6'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_ECHO_CR,
		ST_ECHO,
		ST_ERASE,
		ST_NL_CR,
		ST_NL,
		ST_DUMP_RD,
		ST_DUMP_OUT,
		ST_MARK
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/cle_ram.sv -----
// ----------------------------------------------------------------------------
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/canonical_line_editor.sv -----
// ----------------------------------------------------------------------------
// canonical_line_editor
// Line editing of received bytes with echo, erase and line dump.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   transaction. Output channel (out_valid/out_ready) carries out_kind,
//   out_byte, line_length and last; last flags the final result of a byte.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready
//   and must only be written while the block is idle.
//   in_ready is high only while the sequencer is idle; each byte is worked
//   through one result at a time by a small sequencer around the line RAM.
//   After the input transaction the sequencer passes ST_START before the
//   first result, and ST_DUMP_RD as well when the line dump comes first;
//   echo and erase results follow at one per cycle while the receiver takes
//   them, and each line byte waits for its registered RAM read.
//   The output register holds a result until taken; a stalled receiver
//   stalls the sequencer. Reset empties the line and loads the register
//   defaults; the line RAM itself is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module canonical_line_editor #(
	parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [7:0]                    rx_byte,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [1:0]                    out_kind,
	output logic      [7:0]                    out_byte,
	output logic      [4:0]                    line_length,
	output logic                               last,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [cle_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [5:0]                    cfg_data
);

	import cle_pkg::*;

	localparam int         FW      = $clog2(LINE_DEPTH);
	localparam logic [5:0] DEPTH_W = 6'(LINE_DEPTH);

	state_t state_q, state_d;

	logic          echo_en_q, crlf_q, cr2lf_q;
	logic [5:0]    line_size_q;
	logic [FW-1:0] fill_q, rd_idx_q;
	logic [1:0]    erase_cnt_q;
	logic [7:0]    c_q;
	logic          erase_q, nl_q, fin_q;

	logic [5:0]    limit;
	logic [7:0]    c_map;
	logic          in_acc, is_erase, is_nl, is_ord, can_store, fin_ord;
	logic [5:0]    fill_ext, fill_inc;
	logic [7:0]    rd_data;
	logic          slot_free, emit, emit_last;
	logic [1:0]    emit_kind;
	logic [7:0]    emit_byte;
	state_t        post_st, dump_st;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			echo_en_q   <= 1'b0;
			crlf_q      <= 1'b1;
			cr2lf_q     <= 1'b0;
			line_size_q <= LINE_SIZE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ECHO_ENABLE: echo_en_q   <= cfg_data[0];
				REG_CRLF_EXPAND: crlf_q      <= cfg_data[0];
				REG_CR_TO_LF:    cr2lf_q     <= cfg_data[0];
				REG_LINE_SIZE:   line_size_q <= cfg_data;
				default:         ;
			endcase
		end
	end

	// stored-byte limit is the clamped capacity minus one
	always_comb begin
		priority if (line_size_q < LINE_SIZE_MIN) begin
			limit = LINE_SIZE_MIN - 6'd1;
		end else if (line_size_q > DEPTH_W) begin
			limit = DEPTH_W - 6'd1;
		end else begin
			limit = line_size_q - 6'd1;
		end
	end

	// input decode
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign c_map     = (cr2lf_q && rx_byte == CH_CR) ? CH_LF : rx_byte;
	assign is_erase  = (c_map == CH_BS) || (c_map == CH_DEL);
	assign is_nl     = (c_map == CH_LF) || (c_map == CH_CR);
	assign is_ord    = !is_erase && !is_nl;
	assign fill_ext  = 6'(fill_q);
	assign can_store = is_ord && (fill_ext < limit);
	assign fill_inc  = fill_ext + 6'(can_store);
	assign fin_ord   = is_ord && (fill_inc >= limit);

	cle_ram #(
		.WIDTH (8),
		.DEPTH (LINE_DEPTH)
	) u_line_ram (
		.clk   (clk),
		.we    (in_acc && can_store),
		.waddr (fill_q),
		.wdata (c_map),
		.raddr (rd_idx_q),
		.rdata (rd_data)
	);

	assign slot_free = !out_valid || out_ready;

	assign dump_st = (fill_q == '0) ? ST_MARK : ST_DUMP_RD;

	always_comb begin
		priority if (erase_q) begin
			post_st = ST_ERASE;
		end else if (nl_q) begin
			post_st = crlf_q ? ST_NL_CR : ST_NL;
		end else if (fin_q) begin
			post_st = dump_st;
		end else begin
			post_st = ST_IDLE;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_START;
			end
			ST_START: begin
				if (echo_en_q) begin
					state_d = (crlf_q && c_q == CH_LF) ? ST_ECHO_CR : ST_ECHO;
				end else begin
					state_d = post_st;
				end
			end
			ST_ECHO_CR: begin
				if (slot_free) state_d = ST_ECHO;
			end
			ST_ECHO: begin
				if (slot_free) state_d = post_st;
			end
			ST_ERASE: begin
				if (slot_free && erase_cnt_q == 2'd2) state_d = ST_IDLE;
			end
			ST_NL_CR: begin
				if (slot_free) state_d = ST_NL;
			end
			ST_NL: begin
				if (slot_free) state_d = dump_st;
			end
			ST_DUMP_RD: begin
				state_d = ST_DUMP_OUT;
			end
			ST_DUMP_OUT: begin
				if (slot_free) begin
					state_d = (rd_idx_q + FW'(1) == fill_q) ? ST_MARK : ST_DUMP_RD;
				end
			end
			ST_MARK: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// result selection
	always_comb begin
		emit      = 1'b0;
		emit_kind = KIND_ECHO;
		emit_byte = 8'h00;
		emit_last = 1'b0;
		unique case (state_q)
			ST_ECHO_CR: begin
				emit      = slot_free;
				emit_byte = CH_CR;
			end
			ST_ECHO: begin
				emit      = slot_free;
				emit_byte = c_q;
				emit_last = !(erase_q || fin_q);
			end
			ST_ERASE: begin
				emit      = slot_free;
				emit_byte = (erase_cnt_q == 2'd1) ? CH_SP : CH_BS;
				emit_last = (erase_cnt_q == 2'd2);
			end
			ST_NL_CR: begin
				emit      = slot_free;
				emit_byte = CH_CR;
			end
			ST_NL: begin
				emit      = slot_free;
				emit_byte = CH_LF;
			end
			ST_DUMP_OUT: begin
				emit      = slot_free;
				emit_kind = KIND_LINE;
				emit_byte = rd_data;
			end
			ST_MARK: begin
				emit      = slot_free;
				emit_kind = KIND_END;
				emit_last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			erase_cnt_q <= '0;
			erase_q     <= 1'b0;
			nl_q        <= 1'b0;
			fin_q       <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				erase_q <= is_erase && (fill_q != '0);
				nl_q    <= is_nl;
				fin_q   <= is_nl || fin_ord;
				if (is_erase && fill_q != '0) begin
					fill_q <= fill_q - FW'(1);
				end else if (can_store) begin
					fill_q <= fill_q + FW'(1);
				end
			end
			if (state_q == ST_START) begin
				rd_idx_q    <= '0;
				erase_cnt_q <= '0;
			end
			if (emit && state_q == ST_ERASE) erase_cnt_q <= erase_cnt_q + 2'd1;
			if (emit && state_q == ST_DUMP_OUT) rd_idx_q <= rd_idx_q + FW'(1);
			if (emit && state_q == ST_MARK) fill_q <= '0;
			if (emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) c_q <= c_map;
		if (emit) begin
			out_kind    <= emit_kind;
			out_byte    <= emit_byte;
			line_length <= (emit_kind == KIND_END) ? 5'(fill_q) : 5'd0;
			last        <= emit_last;
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		6'(fill_q) < DEPTH_W)
		else $error("line fill beyond capacity");

	a_mark_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_kind == KIND_END |=> fill_q == '0)
		else $error("line not emptied after end marker");

	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DUMP_OUT |-> rd_idx_q < fill_q)
		else $error("line dump reads past fill");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_last |=> state_q == ST_IDLE)
		else $error("sequencer busy after final result");

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the canonical line editor.
// A scripted run of keystrokes and register writes covers newline, erase on
// empty and held lines, CR mapping, line size clamping and a line that is
// shrunk below its fill. Random typing then runs in phases with fresh
// register settings and several handshake idling mixes. Every result is
// compared field by field against a local line editor model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import cle_pkg::*;

	localparam int LINE_DEPTH    = LINE_DEPTH_DEF;
	localparam int CYCLE_LIMIT   = 400_000;
	localparam int SETTLE_CYCLES = 100;
	localparam int PHASES        = 12;
	localparam int KEYS_PER_PHASE = 28;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [4:0] len;
		logic       last;
	} line_event_t;

	// is_reg: register write of data[5:0] to reg_idx; otherwise data is a keystroke.
	// typed: final result of the keystroke as given here.
	typedef struct packed {
		logic                 is_reg;
		logic [CFG_IDX_W-1:0] reg_idx;
		logic [7:0]           data;
		logic                 typed;
		logic [1:0]           kind;
		logic [7:0]           out_b;
		logic [4:0]           len;
	} keystroke_t;

	localparam int N_KEYS = 26;

	localparam keystroke_t KEYS [0:N_KEYS-1] = '{
		'{1'b0, REG_ECHO_ENABLE, CH_LF,  1'b1, KIND_END,  8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, CH_DEL, 1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, 8'h00,  1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, 8'hFF,  1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, CH_BS,  1'b1, KIND_ECHO, CH_BS,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, 8'h80,  1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, CH_CR,  1'b1, KIND_END,  8'h00,  5'd2},
		'{1'b1, REG_ECHO_ENABLE, 8'd1,   1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b1, REG_CR_TO_LF,    8'd1,   1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b1, REG_CRLF_EXPAND, 8'd0,   1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b1, REG_LINE_SIZE,   8'd2,   1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, 8'h78,  1'b1, KIND_END,  8'h00,  5'd1},
		'{1'b0, REG_ECHO_ENABLE, CH_CR,  1'b1, KIND_END,  8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, CH_DEL, 1'b1, KIND_ECHO, CH_DEL, 5'd0},
		'{1'b1, REG_LINE_SIZE,   8'd0,   1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b1, REG_CRLF_EXPAND, 8'd1,   1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, 8'h55,  1'b1, KIND_END,  8'h00,  5'd1},
		'{1'b1, REG_LINE_SIZE,   8'd63,  1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b1, REG_CR_TO_LF,    8'd0,   1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, 8'h01,  1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, 8'h41,  1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b0, REG_ECHO_ENABLE, 8'hFE,  1'b0, KIND_ECHO, 8'h00,  5'd0},
		'{1'b1, REG_LINE_SIZE,   8'd3,   1'b0, KIND_ECHO, 8'h00,  5'd0},
		// line shrunk below its fill: keystroke dropped, held line ends
		'{1'b0, REG_ECHO_ENABLE, 8'h7E,  1'b1, KIND_END,  8'h00,  5'd3},
		'{1'b0, REG_ECHO_ENABLE, CH_CR,  1'b1, KIND_END,  8'h00,  5'd0},
		'{1'b1, REG_LINE_SIZE,   8'd1,   1'b0, KIND_ECHO, 8'h00,  5'd0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [7:0]           rx_byte = 8'h00;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           out_kind;
	logic [7:0]           out_byte;
	logic [4:0]           line_length;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [5:0]           cfg_data = '0;

	// line editor model
	logic [7:0]  line_mem [LINE_DEPTH];
	logic [4:0]  held = '0;
	logic        echo_on = 1'b0;
	logic        crlf_on = 1'b1;
	logic        cr_map = 1'b0;
	logic [5:0]  size_reg = LINE_SIZE_RST;
	line_event_t line_events [$];

	int unsigned snd_idle = 0;
	int unsigned rcv_idle = 0;
	int          fails = 0;
	int          cycle_cnt = 0;

	canonical_line_editor i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.rx_byte    (rx_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.line_length(line_length),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic void put_event(input logic [1:0] k, input logic [7:0] d,
			input logic [4:0] n);
		line_event_t ev;
		ev = '{kind: k, data: d, len: n, last: 1'b0};
		line_events.push_back(ev);
	endfunction

	function automatic void put_tx(input logic [7:0] c);
		if (crlf_on && c == CH_LF)
			put_event(KIND_ECHO, CH_CR, 5'd0);
		put_event(KIND_ECHO, c, 5'd0);
	endfunction

	function automatic void flush_line();
		for (int i = 0; i < int'(held); i++)
			put_event(KIND_LINE, line_mem[5'(i)], 5'd0);
		put_event(KIND_END, 8'h00, held);
		held = '0;
	endfunction

	function automatic void edit_byte(input logic [7:0] b);
		int          cap;
		int          first;
		logic [7:0]  c;
		line_event_t tail;
		cap = int'(size_reg);
		first = line_events.size();
		c = b;
		if (cap < 2)
			cap = 2;
		if (cap > LINE_DEPTH)
			cap = LINE_DEPTH;
		if (cr_map && c == CH_CR)
			c = CH_LF;
		if (echo_on)
			put_tx(c);
		if (c == CH_BS || c == CH_DEL) begin
			if (held != '0) begin
				held = held - 5'd1;
				put_tx(CH_BS);
				put_tx(CH_SP);
				put_tx(CH_BS);
			end
		end else if (c == CH_LF || c == CH_CR) begin
			put_tx(CH_LF);
			flush_line();
		end else begin
			if (int'(held) < cap - 1) begin
				line_mem[held] = c;
				held = held + 5'd1;
			end
			if (int'(held) >= cap - 1)
				flush_line();
		end
		if (line_events.size() > first) begin
			tail = line_events.pop_back();
			tail.last = 1'b1;
			line_events.push_back(tail);
		end
	endfunction

	function automatic logic [7:0] rand_key(input int unsigned nl_pct);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return 8'($urandom_range(0, 255));
		if (r < 20)
			return $urandom_range(0, 1) ? CH_BS : CH_DEL;
		if (r < 20 + nl_pct)
			return $urandom_range(0, 1) ? CH_CR : CH_LF;
		return 8'($urandom_range(8'h20, 8'h7E));
	endfunction

	task automatic push_rx(input logic [7:0] b);
		if ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < snd_idle);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
		edit_byte(b);
	endtask

	// leaves cfg_valid high; caller lowers it after the last write
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [5:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ECHO_ENABLE: echo_on = d[0];
			REG_CRLF_EXPAND: crlf_on = d[0];
			REG_CR_TO_LF:    cr_map = d[0];
			REG_LINE_SIZE:   size_reg = d;
		endcase
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (line_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_idling(input int mode);
		case (mode % 4)
			0: begin snd_idle = 0;  rcv_idle = 0;  end
			1: begin snd_idle = 48; rcv_idle = 0;  end
			2: begin snd_idle = 0;  rcv_idle = 48; end
			default: begin snd_idle = 38; rcv_idle = 38; end
		endcase
	endtask

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= rcv_idle);

	always @(posedge clk) begin
		line_event_t want;
		if (arst_n && out_valid && out_ready) begin
			if (line_events.size() == 0) begin
				$error("result with nothing pending: out_kind %0d out_byte %0d",
					out_kind, out_byte);
				fails++;
			end else begin
				want = line_events.pop_front();
				check_field("out_kind", want.kind, out_kind);
				check_field("out_byte", want.data, out_byte);
				check_field("line_length", want.len, line_length);
				check_field("last", want.last, last);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("[canonical_line_editor] ERROR");
			$finish;
		end
	end

	initial begin
		line_event_t tail;
		logic [5:0]  sz;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < N_KEYS; k++) begin
			if (KEYS[k].is_reg) begin
				settle();
				set_reg(KEYS[k].reg_idx, KEYS[k].data[5:0]);
				cfg_valid <= 1'b0;
			end else begin
				push_rx(KEYS[k].data);
				if (KEYS[k].typed) begin
					tail = line_events.pop_back();
					tail = '{kind: KEYS[k].kind, data: KEYS[k].out_b,
						len: KEYS[k].len, last: 1'b1};
					line_events.push_back(tail);
				end
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 6)
				0: sz = 6'd32;
				1: sz = 6'd2;
				2: sz = 6'($urandom_range(2, 32));
				3: sz = 6'($urandom_range(0, 63));
				4: sz = 6'd5;
				default: sz = 6'($urandom_range(2, 8));
			endcase
			set_reg(REG_ECHO_ENABLE, 6'($urandom_range(0, 1)));
			set_reg(REG_CRLF_EXPAND, 6'($urandom_range(0, 1)));
			set_reg(REG_CR_TO_LF, 6'($urandom_range(0, 1)));
			set_reg(REG_LINE_SIZE, sz);
			cfg_valid <= 1'b0;
			set_idling(p);
			for (int n = 0; n < KEYS_PER_PHASE; n++)
				push_rx(rand_key((p % 3 == 0) ? 3 : 10));
		end

		settle();
		if (fails == 0)
			$display("[canonical_line_editor] OK");
		else
			$display("[canonical_line_editor] ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cle_pkg.sv
rtl/cle_ram.sv
rtl/canonical_line_editor.sv
test/tb.sv
